>>> src/nsdof_pkg.sv
package nsdof_pkg;

  localparam int unsigned QW = 48;
  localparam int unsigned UW = 47;
  localparam int unsigned AW = 51;

  localparam logic [UW-1:0] STEP_TIME_RST      = 47'd167772;
  localparam logic [UW-1:0] INV_BETA_DT_RST    = 47'd6710886400;
  localparam logic [UW-1:0] INV_BETA_DT_SQ_RST = 47'd671088640000;

  typedef enum logic [2:0] {
    CFG_LINEAR_MODE       = 3'd0,
    CFG_STEP_TIME         = 3'd1,
    CFG_INV_BETA_DT       = 3'd2,
    CFG_INV_BETA_DT_SQ    = 3'd3,
    CFG_COEF_DISP         = 3'd4,
    CFG_COEF_VEL          = 3'd5,
    CFG_COEF_ACC          = 3'd6,
    CFG_INV_EFF_STIFFNESS = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ACC_HOLD,
    ACC_LOAD_NEG_G,
    ACC_ADD_P,
    ACC_SUB_P,
    ACC_LOAD_P_SUB_U,
    ACC_LOAD_P_SUB_V,
    ACC_LOAD_P_SUB_2V,
    ACC_LOAD_P_SUB_A,
    ACC_LOAD_P_SUB_2A
  } acc_op_e;

  typedef enum logic [2:0] {
    MOP_DISP_U,
    MOP_VEL_V,
    MOP_ACC_A,
    MOP_SACC_IES,
    MOP_SACC_IBD,
    MOP_A_ST,
    MOP_DU_IBDSQ,
    MOP_V_IBD
  } mop_e;

  typedef struct packed {
    logic signed [31:0] accel_sample;
    logic               first_sample;
  } in_t;

  typedef struct packed {
    logic signed [QW-1:0] disp_now;
    logic [UW-1:0]        peak_disp;
  } out_t;

  typedef struct packed {
    acc_op_e acc_op;
    logic    mul_start;
    mop_e    mul_op;
    logic    store_un;
    logic    store_du;
    logic    store_vn;
    logic    commit;
    logic    commit_first;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic linear_mode;
    logic out_free;
  } stat_t;

endpackage

>>> src/nsdof_mul.sv
module nsdof_mul (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [nsdof_pkg::QW-1:0]        op_a_i,
  input  logic signed [nsdof_pkg::QW-1:0]        op_b_i,
  input  logic                                   shr25_i,
  output logic                                   done_o,
  output logic signed [nsdof_pkg::QW-1:0]        res_o
);

  logic        busy_q, busy_d;
  logic        rnd_q, rnd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [47:0] ma_q, mb_q;
  logic        neg_q, s25_q;
  logic [95:0] prod_q;
  logic signed [47:0] res_q;

  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [95:0] pp_sh;
  logic [95:0] rsum;
  logic        ovf;
  logic [46:0] mag;
  logic [47:0] res_d;

  always_comb begin
    case (cnt_q)
      2'd0: begin
        pa = ma_q[23:0];
        pb = mb_q[23:0];
      end
      2'd1: begin
        pa = ma_q[23:0];
        pb = mb_q[47:24];
      end
      2'd2: begin
        pa = ma_q[47:24];
        pb = mb_q[23:0];
      end
      default: begin
        pa = ma_q[47:24];
        pb = mb_q[47:24];
      end
    endcase
    pp = 48'(pa) * 48'(pb);
    case (cnt_q)
      2'd0:    pp_sh = {48'd0, pp};
      2'd3:    pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
  end

  always_comb begin
    rsum = prod_q + (s25_q ? (96'd1 << 24) : (96'd1 << 23));
    ovf  = s25_q ? (rsum[95:72] != '0) : (rsum[95:71] != '0);
    mag  = s25_q ? rsum[71:25] : rsum[70:24];
    if (ovf) begin
      res_d = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end else if (neg_q) begin
      res_d = -{1'b0, mag};
    end else begin
      res_d = {1'b0, mag};
    end
  end

  always_comb begin
    busy_d = busy_q;
    rnd_d  = 1'b0;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        rnd_d  = 1'b1;
      end
    end else if (rnd_q) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rnd_q  <= rnd_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q   <= op_a_i[47] ? 48'(-op_a_i) : 48'(op_a_i);
      mb_q   <= op_b_i[47] ? 48'(-op_b_i) : 48'(op_b_i);
      neg_q  <= op_a_i[47] ^ op_b_i[47];
      s25_q  <= shr25_i;
      prod_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_q + pp_sh;
    end
    if (rnd_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/nsdof_datapath.sv
module nsdof_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [nsdof_pkg::QW-1:0]  cfg_data_i,
  input  nsdof_pkg::in_t            in_data_i,
  input  nsdof_pkg::cmd_t           cmd_i,
  output nsdof_pkg::stat_t          stat_o,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output nsdof_pkg::out_t           out_data_o
);

  function automatic logic signed [47:0] sat48(input logic signed [50:0] x);
    if (x[50:47] == 4'b0000 || x[50:47] == 4'b1111) begin
      sat48 = x[47:0];
    end else if (x[50]) begin
      sat48 = 48'h8000_0000_0000;
    end else begin
      sat48 = 48'h7FFF_FFFF_FFFF;
    end
  endfunction

  function automatic logic signed [50:0] sx(input logic signed [47:0] x);
    sx = {{3{x[47]}}, x};
  endfunction

  logic                linear_q;
  logic [46:0]         step_time_q, ibd_q, ibdsq_q, ies_q;
  logic signed [47:0]  coef_disp_q, coef_vel_q, coef_acc_q;

  logic signed [47:0]  u_q, v_q, a_q;
  logic [46:0]         peak_q;
  logic signed [47:0]  un_q, du_q, vn_q;
  logic signed [50:0]  acc_q, acc_d;

  logic                out_valid_q;
  nsdof_pkg::out_t     out_q;

  logic signed [47:0]  op_a, op_b;
  logic                shr25;
  logic                mul_done;
  logic signed [47:0]  mul_res;
  logic signed [47:0]  sacc;
  logic signed [50:0]  p51, g51;
  logic [46:0]         un_mag, peak_new;

  assign sacc = sat48(acc_q);
  assign p51  = sx(mul_res);
  assign g51  = {{11{in_data_i.accel_sample[31]}}, in_data_i.accel_sample, 8'd0};

  always_comb begin
    shr25 = 1'b0;
    unique case (cmd_i.mul_op)
      nsdof_pkg::MOP_DISP_U: begin
        op_a = coef_disp_q;
        op_b = u_q;
      end
      nsdof_pkg::MOP_VEL_V: begin
        op_a = coef_vel_q;
        op_b = v_q;
      end
      nsdof_pkg::MOP_ACC_A: begin
        op_a = coef_acc_q;
        op_b = a_q;
      end
      nsdof_pkg::MOP_SACC_IES: begin
        op_a = sacc;
        op_b = {1'b0, ies_q};
      end
      nsdof_pkg::MOP_SACC_IBD: begin
        op_a  = sacc;
        op_b  = {1'b0, ibd_q};
        shr25 = 1'b1;
      end
      nsdof_pkg::MOP_A_ST: begin
        op_a  = a_q;
        op_b  = {1'b0, step_time_q};
        shr25 = 1'b1;
      end
      nsdof_pkg::MOP_DU_IBDSQ: begin
        op_a = du_q;
        op_b = {1'b0, ibdsq_q};
      end
      default: begin
        op_a = v_q;
        op_b = {1'b0, ibd_q};
      end
    endcase
  end

  nsdof_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .shr25_i (shr25),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_comb begin
    unique case (cmd_i.acc_op)
      nsdof_pkg::ACC_HOLD:          acc_d = acc_q;
      nsdof_pkg::ACC_LOAD_NEG_G:    acc_d = -g51;
      nsdof_pkg::ACC_ADD_P:         acc_d = acc_q + p51;
      nsdof_pkg::ACC_SUB_P:         acc_d = acc_q - p51;
      nsdof_pkg::ACC_LOAD_P_SUB_U:  acc_d = p51 - sx(u_q);
      nsdof_pkg::ACC_LOAD_P_SUB_V:  acc_d = p51 - sx(v_q);
      nsdof_pkg::ACC_LOAD_P_SUB_2V: acc_d = p51 - (sx(v_q) <<< 1);
      nsdof_pkg::ACC_LOAD_P_SUB_A:  acc_d = p51 - sx(a_q);
      nsdof_pkg::ACC_LOAD_P_SUB_2A: acc_d = p51 - (sx(a_q) <<< 1);
      default:                      acc_d = acc_q;
    endcase
  end

  always_comb begin
    if (!un_q[47]) begin
      un_mag = un_q[46:0];
    end else if (un_q == 48'h8000_0000_0000) begin
      un_mag = '1;
    end else begin
      un_mag = 47'(-un_q);
    end
    peak_new = (un_mag > peak_q) ? un_mag : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_q    <= 1'b0;
      step_time_q <= nsdof_pkg::STEP_TIME_RST;
      ibd_q       <= nsdof_pkg::INV_BETA_DT_RST;
      ibdsq_q     <= nsdof_pkg::INV_BETA_DT_SQ_RST;
      coef_disp_q <= '0;
      coef_vel_q  <= '0;
      coef_acc_q  <= '0;
      ies_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (nsdof_pkg::cfg_idx_e'(cfg_idx_i))
        nsdof_pkg::CFG_LINEAR_MODE:       linear_q    <= cfg_data_i[0];
        nsdof_pkg::CFG_STEP_TIME:         step_time_q <= cfg_data_i[46:0];
        nsdof_pkg::CFG_INV_BETA_DT:       ibd_q       <= cfg_data_i[46:0];
        nsdof_pkg::CFG_INV_BETA_DT_SQ:    ibdsq_q     <= cfg_data_i[46:0];
        nsdof_pkg::CFG_COEF_DISP:         coef_disp_q <= cfg_data_i;
        nsdof_pkg::CFG_COEF_VEL:          coef_vel_q  <= cfg_data_i;
        nsdof_pkg::CFG_COEF_ACC:          coef_acc_q  <= cfg_data_i;
        nsdof_pkg::CFG_INV_EFF_STIFFNESS: ies_q       <= cfg_data_i[46:0];
        default:                          linear_q    <= linear_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q         <= '0;
      v_q         <= '0;
      a_q         <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        a_q         <= sacc;
        if (cmd_i.commit_first) begin
          u_q    <= '0;
          v_q    <= '0;
          peak_q <= '0;
        end else begin
          u_q    <= un_q;
          v_q    <= vn_q;
          peak_q <= peak_new;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.store_un) begin
      un_q <= mul_res;
    end
    if (cmd_i.store_du) begin
      du_q <= sacc;
    end
    if (cmd_i.store_vn) begin
      vn_q <= sacc;
    end
    if (cmd_i.commit) begin
      if (cmd_i.commit_first) begin
        out_q.disp_now  <= '0;
        out_q.peak_disp <= '0;
      end else begin
        out_q.disp_now  <= un_q;
        out_q.peak_disp <= peak_new;
      end
    end
  end

  assign stat_o.mul_done    = mul_done;
  assign stat_o.linear_mode = linear_q;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

>>> src/nsdof_ctrl.sv
module nsdof_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              first_i,
  output logic              in_stall_o,
  input  nsdof_pkg::stat_t  stat_i,
  output nsdof_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PD   = 4'd1;
  localparam logic [3:0] S_PV   = 4'd2;
  localparam logic [3:0] S_PA   = 4'd3;
  localparam logic [3:0] S_PEFF = 4'd4;
  localparam logic [3:0] S_UN   = 4'd5;
  localparam logic [3:0] S_DU   = 4'd6;
  localparam logic [3:0] S_VB   = 4'd7;
  localparam logic [3:0] S_VL   = 4'd8;
  localparam logic [3:0] S_VST  = 4'd9;
  localparam logic [3:0] S_AB   = 4'd10;
  localparam logic [3:0] S_AV   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state_q, state_d;
  logic       first_q, first_d;

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    cmd_o   = '{acc_op: nsdof_pkg::ACC_HOLD, mul_op: nsdof_pkg::MOP_DISP_U, default: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          first_d      = first_i;
          cmd_o.acc_op = nsdof_pkg::ACC_LOAD_NEG_G;
          if (first_i) begin
            state_d = S_DONE;
          end else begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_op    = nsdof_pkg::MOP_DISP_U;
            state_d         = S_PD;
          end
        end
      end
      S_PD: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_op    = nsdof_pkg::ACC_ADD_P;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = nsdof_pkg::MOP_VEL_V;
          state_d         = S_PV;
        end
      end
      S_PV: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_op    = nsdof_pkg::ACC_ADD_P;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = nsdof_pkg::MOP_ACC_A;
          state_d         = S_PA;
        end
      end
      S_PA: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_op = nsdof_pkg::ACC_ADD_P;
          state_d      = S_PEFF;
        end
      end
      S_PEFF: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = nsdof_pkg::MOP_SACC_IES;
        state_d         = S_UN;
      end
      S_UN: begin
        if (stat_i.mul_done) begin
          cmd_o.store_un = 1'b1;
          cmd_o.acc_op   = nsdof_pkg::ACC_LOAD_P_SUB_U;
          state_d        = S_DU;
        end
      end
      S_DU: begin
        cmd_o.store_du  = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = nsdof_pkg::MOP_SACC_IBD;
        state_d         = S_VB;
      end
      S_VB: begin
        if (stat_i.mul_done) begin
          if (stat_i.linear_mode) begin
            cmd_o.acc_op    = nsdof_pkg::ACC_LOAD_P_SUB_2V;
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_op    = nsdof_pkg::MOP_A_ST;
            state_d         = S_VL;
          end else begin
            cmd_o.acc_op = nsdof_pkg::ACC_LOAD_P_SUB_V;
            state_d      = S_VST;
          end
        end
      end
      S_VL: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_op = nsdof_pkg::ACC_SUB_P;
          state_d      = S_VST;
        end
      end
      S_VST: begin
        cmd_o.store_vn  = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = nsdof_pkg::MOP_DU_IBDSQ;
        state_d         = S_AB;
      end
      S_AB: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_op    = stat_i.linear_mode ? nsdof_pkg::ACC_LOAD_P_SUB_2A
                                               : nsdof_pkg::ACC_LOAD_P_SUB_A;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = nsdof_pkg::MOP_V_IBD;
          state_d         = S_AV;
        end
      end
      S_AV: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_op = nsdof_pkg::ACC_SUB_P;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit       = 1'b1;
          cmd_o.commit_first = first_q;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> src/newmark_sdof_peak_response_top.sv
// Newmark-beta step of a unit-mass damped oscillator, one ground-acceleration request at a
// time, with the running peak of |displacement|. A request marked first_sample resets the
// record without any multiply; any other request runs seven products with beta one quarter
// and eight with beta one sixth (linear mode), all on a single shared 48x48 fixed-point
// multiplier that forms each product from four 24x24 partial products plus a rounding step.
// in_stall_o is high while a step is in progress; a finished result waits in the output
// register and the next request is taken as soon as that step has handed its result over.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only
// while the block is idle, and the block itself does not enforce this.
module newmark_sdof_peak_response_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [nsdof_pkg::QW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  nsdof_pkg::in_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output nsdof_pkg::out_t           out_data_o
);

  nsdof_pkg::cmd_t  cmd;
  nsdof_pkg::stat_t stat;

  nsdof_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .first_i    (in_data_i.first_sample),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nsdof_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
